/* hdl/apoit_pkg.sv */
// Shared types and constants of the inactivity auto-power-off timer.
package apoit_pkg;

  // Default width of the tick counters.
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Field and register widths.
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned MODE_W   = 8;
  localparam int unsigned SECS_W   = 16;
  localparam int unsigned DEPTH_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [15:0] RATE_RST      = 16'd1500;
  localparam logic [15:0] LEAD_SECS_RST = 16'd120;

  // Bucketed warning leads and the timeout limits that select them.
  localparam logic [15:0] LEAD_SHORT_S  = 16'd120;
  localparam logic [15:0] LEAD_MID_S    = 16'd180;
  localparam logic [15:0] LEAD_LONG_S   = 16'd300;
  localparam logic [15:0] TIMEOUT_SHORT_MAX = 16'd1800;
  localparam logic [15:0] TIMEOUT_MID_MAX   = 16'd3600;

  // System modes that reload the countdown on a tick.
  localparam logic [MODE_W-1:0] MODE_TRANSIENT_A = 8'd1;
  localparam logic [MODE_W-1:0] MODE_TRANSIENT_B = 8'd2;

  // Largest nesting depth of long processes.
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 3'd0,
    OP_ACTIVITY = 3'd1,
    OP_RELOAD   = 3'd2,
    OP_PREP     = 3'd3,
    OP_LP_BEGIN = 3'd4,
    OP_LP_END   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MSG_NONE    = 2'd0,
    MSG_WARN    = 2'd1,
    MSG_EXPIRED = 2'd2,
    MSG_CLEARED = 2'd3
  } msg_e;

  typedef enum logic [2:0] {
    PH_DISABLED = 3'd0,
    PH_ARMED    = 3'd1,
    PH_WARN     = 3'd2,
    PH_CRIT     = 3'd3,
    PH_OFF      = 3'd4
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_RATE      = 2'd1,
    CFG_OVERRIDE  = 2'd2,
    CFG_LEAD_SECS = 2'd3
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    op_e  op;
    logic div_start;
    logic push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

/* hdl/auto_power_off_inactivity_timer_top.sv */
// Top level of the inactivity auto-power-off timer.
//
// Requests arrive on the input channel (in_valid_i / in_stall_o) with an
// opcode and the inhibit, busy, mode and test flags; each request yields
// exactly one result on the output channel (out_valid_o / out_stall_i).
// Registers are written through cfg_we_i, cfg_index_i and cfg_wdata_i;
// the user must write them only while no request is in flight, as the
// block itself does not enforce it. One request is processed at a time:
// it is captured, executed and handed to the output register, and a tick
// inside the warning lead also runs the bit-serial divider that turns the
// remaining ticks into seconds before its hand-off. The next request can
// be accepted in the cycle after the result moves into the output register.
// While the receiver stalls, the output holds its result unchanged; the next
// request still runs up to its hand-off, and the one after it waits.
// Reset leaves the timer disabled with a 1500 tick-per-second rate, clears
// the nesting depth and the activity flag, and empties the output.
module auto_power_off_inactivity_timer_top #(
  parameter int unsigned COUNT_WIDTH = apoit_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [apoit_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic                              panel_inhibit_i,
  input  logic                              ui_busy_i,
  input  logic [apoit_pkg::MODE_W-1:0]      system_mode_i,
  input  logic                              test_mode_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        message_o,
  output logic                              power_off_command_o,
  output logic                              seconds_valid_o,
  output logic [apoit_pkg::SECS_W-1:0]      seconds_remaining_o,
  output logic [2:0]                        timer_state_o,
  input  logic                              cfg_we_i,
  input  logic [apoit_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [apoit_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  apoit_pkg::cmd_t cmd;
  apoit_pkg::sts_t sts;

  apoit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  apoit_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .panel_inhibit_i     (panel_inhibit_i),
    .ui_busy_i           (ui_busy_i),
    .system_mode_i       (system_mode_i),
    .test_mode_i         (test_mode_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .message_o           (message_o),
    .power_off_command_o (power_off_command_o),
    .seconds_valid_o     (seconds_valid_o),
    .seconds_remaining_o (seconds_remaining_o),
    .timer_state_o       (timer_state_o)
  );

endmodule

/* hdl/apoit_div.sv */
// Restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
module apoit_div #(
  parameter int unsigned COUNT_WIDTH = apoit_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COUNT_WIDTH-1:0]        dividend_i,
  input  logic [15:0]                   divisor_i,
  output logic                          done_o,
  output logic [apoit_pkg::SECS_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(COUNT_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [15:0]            rem_q, rem_d;
  logic [COUNT_WIDTH-1:0] quo_q, quo_d;
  logic [16:0]            trial;
  logic [16:0]            diff;
  logic                   fits;

  // One shift-subtract step.
  assign trial = {rem_q, quo_q[COUNT_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(COUNT_WIDTH);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[15:0] : trial[15:0];
      quo_d = {quo_q[COUNT_WIDTH-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;

  // Clamp the quotient to the seconds field.
  generate
    if (COUNT_WIDTH > apoit_pkg::SECS_W) begin : g_sat
      assign quot_o = (|quo_q[COUNT_WIDTH-1:apoit_pkg::SECS_W]) ? '1
                                                               : quo_q[apoit_pkg::SECS_W-1:0];
    end else begin : g_nosat
      assign quot_o = quo_q[apoit_pkg::SECS_W-1:0];
    end
  endgenerate

endmodule

/* hdl/apoit_dp.sv */
// Datapath: configuration, countdown state, result and output registers.
module apoit_dp #(
  parameter int unsigned COUNT_WIDTH = apoit_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  apoit_pkg::cmd_t                   cmd_i,
  output apoit_pkg::sts_t                   sts_o,
  input  logic                              panel_inhibit_i,
  input  logic                              ui_busy_i,
  input  logic [apoit_pkg::MODE_W-1:0]      system_mode_i,
  input  logic                              test_mode_i,
  input  logic                              cfg_we_i,
  input  logic [apoit_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [apoit_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        message_o,
  output logic                              power_off_command_o,
  output logic                              seconds_valid_o,
  output logic [apoit_pkg::SECS_W-1:0]      seconds_remaining_o,
  output logic [2:0]                        timer_state_o
);

  localparam logic [32:0] SAT_LIM = (33'd1 << COUNT_WIDTH) - 33'd1;
  localparam logic [32:0] LEAD_RST_FULL =
    33'(apoit_pkg::LEAD_SECS_RST) * 33'(apoit_pkg::RATE_RST);
  localparam logic [COUNT_WIDTH-1:0] LEAD_RST =
    (LEAD_RST_FULL > SAT_LIM) ? {COUNT_WIDTH{1'b1}} : LEAD_RST_FULL[COUNT_WIDTH-1:0];

  // Clamp a product of seconds and rate to the counter width.
  function automatic logic [COUNT_WIDTH-1:0] sat_ticks(input logic [31:0] p);
    logic [32:0] p33;
    p33 = {1'b0, p};
    return (p33 > SAT_LIM) ? {COUNT_WIDTH{1'b1}} : p[COUNT_WIDTH-1:0];
  endfunction

  // Configuration registers.
  logic [15:0] timeout_q, timeout_d;
  logic [15:0] rate_q, rate_d;
  logic        ovr_q, ovr_d;
  logic [15:0] lsec_q, lsec_d;

  // Countdown state.
  logic [COUNT_WIDTH-1:0]           ticks_left_q, ticks_left_d;
  logic [COUNT_WIDTH-1:0]           reload_q, reload_d;
  logic [COUNT_WIDTH-1:0]           lead_q, lead_d;
  apoit_pkg::phase_e                phase_q, phase_d;
  logic                             pending_q, pending_d;
  logic [apoit_pkg::DEPTH_W-1:0]    depth_q, depth_d;

  // Captured request flags.
  logic                             inhibit_q, busy_q, test_q;
  logic [apoit_pkg::MODE_W-1:0]     mode_q;

  // Result being built.
  apoit_pkg::msg_e                  res_msg_q;
  logic                             res_power_q, res_valid_q;
  logic [apoit_pkg::SECS_W-1:0]     res_secs_q;
  apoit_pkg::phase_e                res_state_q;

  // Output register.
  logic                             out_valid_q;
  apoit_pkg::msg_e                  out_msg_q;
  logic                             out_power_q, out_svalid_q;
  logic [apoit_pkg::SECS_W-1:0]     out_secs_q;
  apoit_pkg::phase_e                out_state_q;

  // Step outcome.
  apoit_pkg::msg_e                  msg;
  logic                             power;
  logic                             need_div;

  // Conversion of seconds into ticks.
  logic [15:0]                      rate_eff;
  logic [15:0]                      tout_new;
  logic                             ovr_new;
  logic [15:0]                      lsec_new;
  logic [15:0]                      lead_sel;
  logic [31:0]                      reload_prod;
  logic [31:0]                      lead_prod;
  logic [COUNT_WIDTH-1:0]           reload_new;

  logic                             div_done;
  logic [apoit_pkg::SECS_W-1:0]     div_quot;

  assign rate_eff = (rate_q == 16'd0) ? 16'd1 : rate_q;

  // Timeout, override and lead-seconds values as they stand after a write in this cycle.
  always_comb begin
    tout_new = timeout_q;
    ovr_new  = ovr_q;
    lsec_new = lsec_q;
    if (cfg_we_i) begin
      unique case (apoit_pkg::cfg_idx_e'(cfg_index_i))
        apoit_pkg::CFG_TIMEOUT:   tout_new = cfg_wdata_i;
        apoit_pkg::CFG_OVERRIDE:  ovr_new  = cfg_wdata_i[0];
        apoit_pkg::CFG_LEAD_SECS: lsec_new = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Warning lead in seconds.
  always_comb begin
    if (ovr_new) begin
      lead_sel = lsec_new;
    end else if (tout_new <= apoit_pkg::TIMEOUT_SHORT_MAX) begin
      lead_sel = apoit_pkg::LEAD_SHORT_S;
    end else if (tout_new <= apoit_pkg::TIMEOUT_MID_MAX) begin
      lead_sel = apoit_pkg::LEAD_MID_S;
    end else begin
      lead_sel = apoit_pkg::LEAD_LONG_S;
    end
  end

  assign reload_prod = 32'(tout_new) * 32'(rate_eff);
  assign lead_prod   = 32'(lead_sel) * 32'(rate_eff);
  assign reload_new  = (tout_new == 16'd0) ? {COUNT_WIDTH{1'b1}} : sat_ticks(reload_prod);

  // Request execution and configuration writes.
  always_comb begin
    logic do_reload;
    logic [COUNT_WIDTH-1:0] dec;
    do_reload    = 1'b0;
    dec          = ticks_left_q - COUNT_WIDTH'(1);
    msg          = apoit_pkg::MSG_NONE;
    power        = 1'b0;
    need_div     = 1'b0;
    timeout_d    = timeout_q;
    rate_d       = rate_q;
    ovr_d        = ovr_q;
    lsec_d       = lsec_q;
    ticks_left_d = ticks_left_q;
    reload_d     = reload_q;
    lead_d       = lead_q;
    phase_d      = phase_q;
    pending_d    = pending_q;
    depth_d      = depth_q;

    if (cmd_i.exec) begin
      case (cmd_i.op)
        apoit_pkg::OP_TICK: begin
          if (phase_q != apoit_pkg::PH_DISABLED && depth_q == '0) begin
            pending_d = 1'b0;
            if (pending_q || inhibit_q || busy_q || test_q ||
                mode_q == apoit_pkg::MODE_TRANSIENT_A ||
                mode_q == apoit_pkg::MODE_TRANSIENT_B) begin
              do_reload = 1'b1;
            end else if (ticks_left_q != '0) begin
              ticks_left_d = dec;
              if (dec == '0) begin
                phase_d = apoit_pkg::PH_CRIT;
                msg     = apoit_pkg::MSG_EXPIRED;
              end else if (dec <= lead_q) begin
                if (phase_q != apoit_pkg::PH_WARN) begin
                  phase_d = apoit_pkg::PH_WARN;
                  msg     = apoit_pkg::MSG_WARN;
                end
                need_div = 1'b1;
              end
            end
          end
        end
        apoit_pkg::OP_ACTIVITY: pending_d = 1'b1;
        apoit_pkg::OP_RELOAD:   do_reload = 1'b1;
        apoit_pkg::OP_PREP: begin
          if (phase_q == apoit_pkg::PH_CRIT) begin
            phase_d = apoit_pkg::PH_OFF;
            power   = 1'b1;
          end
        end
        apoit_pkg::OP_LP_BEGIN: begin
          if (depth_q != apoit_pkg::DEPTH_MAX) begin
            depth_d = depth_q + apoit_pkg::DEPTH_W'(1);
          end
        end
        apoit_pkg::OP_LP_END: begin
          if (depth_q != '0) begin
            depth_d = depth_q - apoit_pkg::DEPTH_W'(1);
            if (depth_q == apoit_pkg::DEPTH_W'(1)) begin
              do_reload = 1'b1;
            end
          end
        end
        default: ;
      endcase

      // Reload clears a shown warning.
      if (do_reload) begin
        ticks_left_d = reload_q;
        if (phase_q == apoit_pkg::PH_WARN) begin
          phase_d = apoit_pkg::PH_ARMED;
          msg     = apoit_pkg::MSG_CLEARED;
        end
      end
    end

    if (cfg_we_i) begin
      unique case (apoit_pkg::cfg_idx_e'(cfg_index_i))
        apoit_pkg::CFG_TIMEOUT: begin
          timeout_d    = cfg_wdata_i;
          reload_d     = reload_new;
          ticks_left_d = reload_new;
          lead_d       = sat_ticks(lead_prod);
          phase_d      = (cfg_wdata_i == 16'd0) ? apoit_pkg::PH_DISABLED
                                                : apoit_pkg::PH_ARMED;
        end
        apoit_pkg::CFG_RATE: rate_d = cfg_wdata_i;
        apoit_pkg::CFG_OVERRIDE: begin
          ovr_d  = cfg_wdata_i[0];
          lead_d = sat_ticks(lead_prod);
        end
        apoit_pkg::CFG_LEAD_SECS: begin
          lsec_d = cfg_wdata_i;
          lead_d = sat_ticks(lead_prod);
        end
        default: ;
      endcase
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= '0;
      rate_q       <= apoit_pkg::RATE_RST;
      ovr_q        <= 1'b0;
      lsec_q       <= apoit_pkg::LEAD_SECS_RST;
      ticks_left_q <= '1;
      reload_q     <= '1;
      lead_q       <= LEAD_RST;
      phase_q      <= apoit_pkg::PH_DISABLED;
      pending_q    <= 1'b0;
      depth_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      timeout_q    <= timeout_d;
      rate_q       <= rate_d;
      ovr_q        <= ovr_d;
      lsec_q       <= lsec_d;
      ticks_left_q <= ticks_left_d;
      reload_q     <= reload_d;
      lead_q       <= lead_d;
      phase_q      <= phase_d;
      pending_q    <= pending_d;
      depth_q      <= depth_d;
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request flags, result and output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      inhibit_q <= panel_inhibit_i;
      busy_q    <= ui_busy_i;
      mode_q    <= system_mode_i;
      test_q    <= test_mode_i;
    end
    if (cmd_i.exec) begin
      res_msg_q   <= msg;
      res_power_q <= power;
      res_valid_q <= need_div;
      res_secs_q  <= '0;
      res_state_q <= phase_d;
    end else if (div_done) begin
      res_secs_q  <= div_quot;
    end
    if (cmd_i.push) begin
      out_msg_q    <= res_msg_q;
      out_power_q  <= res_power_q;
      out_svalid_q <= res_valid_q;
      out_secs_q   <= res_secs_q;
      out_state_q  <= res_state_q;
    end
  end

  apoit_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (ticks_left_q),
    .divisor_i  (rate_eff),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign sts_o.need_div = need_div;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o         = out_valid_q;
  assign message_o           = out_msg_q;
  assign power_off_command_o = out_power_q;
  assign seconds_valid_o     = out_svalid_q;
  assign seconds_remaining_o = out_secs_q;
  assign timer_state_o       = out_state_q;

`ifndef ASSERT_OFF
  // The count never exceeds its reload value.
  a_count_le_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticks_left_q <= reload_q)
    else $error("count above reload value");

  // A seconds report only comes with the warning state.
  a_secs_in_warn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_svalid_q |-> out_state_q == apoit_pkg::PH_WARN)
    else $error("seconds reported outside warning");

  // The power-off command only comes with the powering-off state.
  a_power_in_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_power_q |-> out_state_q == apoit_pkg::PH_OFF)
    else $error("power-off command outside powering off");
`endif

endmodule

/* hdl/apoit_ctrl.sv */
// Controller: sequences capture, execution, division and result hand-off.
module apoit_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [apoit_pkg::OPCODE_W-1:0]    opcode_i,
  output apoit_pkg::cmd_t                   cmd_o,
  input  apoit_pkg::sts_t                   sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV_START,
    S_DIV_WAIT,
    S_PUSH
  } state_e;

  state_e          state_q, state_d;
  apoit_pkg::op_e  op_q, op_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
          op_d    = apoit_pkg::op_e'(opcode_i);
        end
      end
      S_EXEC:      state_d = sts_i.need_div ? S_DIV_START : S_PUSH;
      S_DIV_START: state_d = S_DIV_WAIT;
      S_DIV_WAIT:  state_d = sts_i.div_done ? S_PUSH : S_DIV_WAIT;
      S_PUSH:      state_d = sts_i.out_free ? S_IDLE : S_PUSH;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= apoit_pkg::OP_TICK;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Commands to the datapath.
  assign in_stall_o      = state_q != S_IDLE;
  assign cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec      = state_q == S_EXEC;
  assign cmd_o.op        = op_q;
  assign cmd_o.div_start = state_q == S_DIV_START;
  assign cmd_o.push      = (state_q == S_PUSH) && sts_i.out_free;

`ifndef ASSERT_OFF
  // The divider finishes only while the controller waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == S_DIV_WAIT)
    else $error("divider done outside wait state");
`endif

endmodule

/* sim/tb_auto_power_off_inactivity_timer_top.sv */
// Self-checking testbench of the inactivity auto-power-off timer top level.
module tb_auto_power_off_inactivity_timer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = apoit_pkg::COUNT_WIDTH_DEF;
  localparam logic [CW-1:0] COUNT_ALL_ONES = '1;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_COUNT = 16;
  localparam int unsigned REQS_PER_PHASE = 46;
  localparam int unsigned NEST_DEPTH = 6;
  localparam logic [apoit_pkg::OPCODE_W-1:0] OP_UNDEF_A = 3'd6;
  localparam logic [apoit_pkg::OPCODE_W-1:0] OP_UNDEF_B = 3'd7;

  typedef struct {
    logic [apoit_pkg::OPCODE_W-1:0] opcode;
    logic                           inhibit;
    logic                           busy;
    logic [apoit_pkg::MODE_W-1:0]   mode;
    logic                           test;
  } timer_req_t;

  typedef struct {
    apoit_pkg::msg_e              msg;
    logic                         power;
    logic                         secs_valid;
    logic [apoit_pkg::SECS_W-1:0] secs;
    apoit_pkg::phase_e            state;
  } timer_res_t;

  // Clock, reset and block signals.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [apoit_pkg::OPCODE_W-1:0] opcode = '0;
  logic panel_inhibit = 1'b0;
  logic ui_busy = 1'b0;
  logic [apoit_pkg::MODE_W-1:0] system_mode = '0;
  logic test_mode = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] message;
  logic power_off;
  logic secs_valid;
  logic [apoit_pkg::SECS_W-1:0] secs_remaining;
  logic [2:0] timer_state;
  logic cfg_we = 1'b0;
  logic [apoit_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [apoit_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Traffic shaping.
  bit sender_idles = 1'b1;
  logic receiver_idles = 1'b0;
  int unsigned burst_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;
  logic [5:0] stall_epoch = '0;
  int unsigned stall_pct = 0;

  // Bookkeeping.
  timer_res_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Predictor copy of the registers and the timer state.
  logic [15:0] reg_timeout;
  logic [15:0] reg_rate;
  logic        reg_override;
  logic [15:0] reg_lead_secs;
  logic [CW-1:0] ticks_left;
  logic [CW-1:0] reload_ticks;
  logic [CW-1:0] lead_ticks;
  apoit_pkg::phase_e phase;
  logic          activity_pending;
  logic [apoit_pkg::DEPTH_W-1:0] lp_depth;

  auto_power_off_inactivity_timer_top uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .opcode_i            (opcode),
    .panel_inhibit_i     (panel_inhibit),
    .ui_busy_i           (ui_busy),
    .system_mode_i       (system_mode),
    .test_mode_i         (test_mode),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .message_o           (message),
    .power_off_command_o (power_off),
    .seconds_valid_o     (secs_valid),
    .seconds_remaining_o (secs_remaining),
    .timer_state_o       (timer_state),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_wdata_i         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A zero tick rate behaves as one tick per second.
  function automatic logic [CW-1:0] eff_rate();
    return (reg_rate == 16'd0) ? CW'(1) : CW'(reg_rate);
  endfunction

  // Seconds to ticks, exact product saturated to the counter width.
  function automatic logic [CW-1:0] secs_to_ticks(input logic [15:0] s);
    logic [63:0] prod;
    prod = 64'(s) * 64'(eff_rate());
    return (prod > 64'(COUNT_ALL_ONES)) ? COUNT_ALL_ONES : prod[CW-1:0];
  endfunction

  // Warning lead from the override or from the timeout bucket.
  function automatic void refresh_lead();
    logic [15:0] s;
    if (reg_override) s = reg_lead_secs;
    else if (reg_timeout <= apoit_pkg::TIMEOUT_SHORT_MAX) s = apoit_pkg::LEAD_SHORT_S;
    else if (reg_timeout <= apoit_pkg::TIMEOUT_MID_MAX) s = apoit_pkg::LEAD_MID_S;
    else s = apoit_pkg::LEAD_LONG_S;
    lead_ticks = secs_to_ticks(s);
  endfunction

  // Reload the count; a shown warning is withdrawn.
  function automatic apoit_pkg::msg_e restart_count();
    ticks_left = reload_ticks;
    if (phase == apoit_pkg::PH_WARN) begin
      phase = apoit_pkg::PH_ARMED;
      return apoit_pkg::MSG_CLEARED;
    end
    return apoit_pkg::MSG_NONE;
  endfunction

  function automatic void init_model();
    reg_timeout = '0;
    reg_rate = apoit_pkg::RATE_RST;
    reg_override = 1'b0;
    reg_lead_secs = apoit_pkg::LEAD_SECS_RST;
    reload_ticks = COUNT_ALL_ONES;
    ticks_left = reload_ticks;
    lead_ticks = secs_to_ticks(apoit_pkg::LEAD_SHORT_S);
    phase = apoit_pkg::PH_DISABLED;
    activity_pending = 1'b0;
    lp_depth = '0;
  endfunction

  function automatic void apply_reg_write(input apoit_pkg::cfg_idx_e idx,
                                          input logic [15:0] val);
    case (idx)
      apoit_pkg::CFG_TIMEOUT: begin
        reg_timeout = val;
        if (val == 16'd0) begin
          reload_ticks = COUNT_ALL_ONES;
          phase = apoit_pkg::PH_DISABLED;
        end else begin
          reload_ticks = secs_to_ticks(val);
          phase = apoit_pkg::PH_ARMED;
        end
        refresh_lead();
        ticks_left = reload_ticks;
      end
      apoit_pkg::CFG_RATE: reg_rate = val;
      apoit_pkg::CFG_OVERRIDE: begin
        reg_override = val[0];
        refresh_lead();
      end
      apoit_pkg::CFG_LEAD_SECS: begin
        reg_lead_secs = val;
        refresh_lead();
      end
      default: ;
    endcase
  endfunction

  // Works out the result of one request and advances the predictor state.
  function automatic timer_res_t predict_timer_result(input timer_req_t r);
    timer_res_t res;
    logic [CW-1:0] quot;
    logic reload_now;
    res.msg = apoit_pkg::MSG_NONE;
    res.power = 1'b0;
    res.secs_valid = 1'b0;
    res.secs = '0;
    case (r.opcode)
      apoit_pkg::OP_TICK: begin
        if (phase != apoit_pkg::PH_DISABLED && lp_depth == '0) begin
          reload_now = activity_pending || r.inhibit || r.busy || r.test ||
                       r.mode == apoit_pkg::MODE_TRANSIENT_A ||
                       r.mode == apoit_pkg::MODE_TRANSIENT_B;
          activity_pending = 1'b0;
          if (reload_now) begin
            res.msg = restart_count();
          end else if (ticks_left != '0) begin
            ticks_left = ticks_left - CW'(1);
            if (ticks_left == '0) begin
              phase = apoit_pkg::PH_CRIT;
              res.msg = apoit_pkg::MSG_EXPIRED;
            end else if (ticks_left <= lead_ticks) begin
              if (phase != apoit_pkg::PH_WARN) begin
                phase = apoit_pkg::PH_WARN;
                res.msg = apoit_pkg::MSG_WARN;
              end
              quot = ticks_left / eff_rate();
              res.secs = (quot > CW'(16'hFFFF)) ? 16'hFFFF : quot[15:0];
              res.secs_valid = 1'b1;
            end
          end
        end
      end
      apoit_pkg::OP_ACTIVITY: activity_pending = 1'b1;
      apoit_pkg::OP_RELOAD: res.msg = restart_count();
      apoit_pkg::OP_PREP: begin
        if (phase == apoit_pkg::PH_CRIT) begin
          phase = apoit_pkg::PH_OFF;
          res.power = 1'b1;
        end
      end
      apoit_pkg::OP_LP_BEGIN: begin
        if (lp_depth != apoit_pkg::DEPTH_MAX) lp_depth = lp_depth + apoit_pkg::DEPTH_W'(1);
      end
      apoit_pkg::OP_LP_END: begin
        if (lp_depth != '0) begin
          lp_depth = lp_depth - apoit_pkg::DEPTH_W'(1);
          if (lp_depth == '0) res.msg = restart_count();
        end
      end
      default: ;
    endcase
    res.state = phase;
    return res;
  endfunction

  function automatic timer_req_t mk_req(input logic [apoit_pkg::OPCODE_W-1:0] op,
                                        input logic inh = 1'b0,
                                        input logic busy = 1'b0,
                                        input logic [apoit_pkg::MODE_W-1:0] mode = '0,
                                        input logic tst = 1'b0);
    timer_req_t r;
    r.opcode = op;
    r.inhibit = inh;
    r.busy = busy;
    r.mode = mode;
    r.test = tst;
    return r;
  endfunction

  // Mostly plain ticks so that countdowns run to warning and expiry.
  function automatic timer_req_t random_request();
    timer_req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.inhibit = 1'($urandom_range(1));
    r.busy = 1'($urandom_range(1));
    r.test = 1'($urandom_range(1));
    r.mode = 8'($urandom_range(255));
    if (pick < 72) begin
      r.opcode = apoit_pkg::OP_TICK;
      r.inhibit = 1'b0;
      r.busy = 1'b0;
      r.test = 1'b0;
      if (r.mode == apoit_pkg::MODE_TRANSIENT_A || r.mode == apoit_pkg::MODE_TRANSIENT_B ||
          $urandom_range(2) != 0)
        r.mode = '0;
      // An occasional reload cause on a tick.
      if ($urandom_range(15) == 0) begin
        case ($urandom_range(4))
          0: r.inhibit = 1'b1;
          1: r.busy = 1'b1;
          2: r.test = 1'b1;
          3: r.mode = apoit_pkg::MODE_TRANSIENT_A;
          default: r.mode = apoit_pkg::MODE_TRANSIENT_B;
        endcase
      end
    end else if (pick < 77) r.opcode = apoit_pkg::OP_ACTIVITY;
    else if (pick < 81) r.opcode = apoit_pkg::OP_RELOAD;
    else if (pick < 87) r.opcode = apoit_pkg::OP_PREP;
    else if (pick < 91) r.opcode = apoit_pkg::OP_LP_BEGIN;
    else if (pick < 97) r.opcode = apoit_pkg::OP_LP_END;
    else r.opcode = $urandom_range(1) ? OP_UNDEF_A : OP_UNDEF_B;
    return r;
  endfunction

  // Offers one request, with a possible idle gap at the start of each burst when sender_idles is set.
  task automatic send_request(input timer_req_t r);
    int unsigned gap;
    gap = 0;
    if (sender_idles) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(12, 1);
        case ($urandom_range(9))
          0, 1, 2: gap = 0;
          3: gap = $urandom_range(40, 15);
          default: gap = $urandom_range(6, 1);
        endcase
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    opcode <= r.opcode;
    panel_inhibit <= r.inhibit;
    ui_busy <= r.busy;
    system_mode <= r.mode;
    test_mode <= r.test;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_timer_result(r));
  endtask

  // Stops offering and waits for every expected result.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input apoit_pkg::cfg_idx_e idx, input logic [15:0] val);
    wait_until_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg_write(idx, val);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  // Disabled after reset: ticks, prep and undefined opcodes change nothing.
  task automatic test_disabled_state();
    send_request(mk_req(apoit_pkg::OP_TICK, 1'b1, 1'b1, 8'hFF, 1'b1));
    send_request(mk_req(OP_UNDEF_A));
    send_request(mk_req(OP_UNDEF_B, 1'b1, 1'b1, 8'hFF, 1'b1));
    send_request(mk_req(apoit_pkg::OP_PREP));
    send_request(mk_req(apoit_pkg::OP_LP_END));
    send_request(mk_req(apoit_pkg::OP_ACTIVITY));
  endtask

  // Short countdown through warning, expiry, power-off, rewarning and clearing.
  task automatic test_countdown_expiry();
    write_reg(apoit_pkg::CFG_RATE, 16'd1);
    write_reg(apoit_pkg::CFG_TIMEOUT, 16'd3);
    // The activity flag kept from the disabled state reloads first.
    send_request(mk_req(apoit_pkg::OP_TICK));
    repeat (4) send_request(mk_req(apoit_pkg::OP_TICK));
    send_request(mk_req(apoit_pkg::OP_PREP));
    send_request(mk_req(apoit_pkg::OP_RELOAD));
    send_request(mk_req(apoit_pkg::OP_TICK));
    send_request(mk_req(apoit_pkg::OP_ACTIVITY));
    send_request(mk_req(apoit_pkg::OP_TICK));
  endtask

  // Each reload cause carried in a tick's flags, and suspension by long processes.
  task automatic test_reload_causes();
    write_reg(apoit_pkg::CFG_TIMEOUT, 16'd5);
    send_request(mk_req(apoit_pkg::OP_TICK));
    send_request(mk_req(apoit_pkg::OP_TICK, 1'b1));
    send_request(mk_req(apoit_pkg::OP_TICK, 1'b0, 1'b1));
    send_request(mk_req(apoit_pkg::OP_TICK, 1'b0, 1'b0, apoit_pkg::MODE_TRANSIENT_A));
    send_request(mk_req(apoit_pkg::OP_TICK, 1'b0, 1'b0, apoit_pkg::MODE_TRANSIENT_B));
    send_request(mk_req(apoit_pkg::OP_TICK, 1'b0, 1'b0, '0, 1'b1));
    send_request(mk_req(apoit_pkg::OP_TICK, 1'b0, 1'b0, 8'd3));
    send_request(mk_req(apoit_pkg::OP_LP_BEGIN));
    send_request(mk_req(apoit_pkg::OP_LP_BEGIN));
    send_request(mk_req(apoit_pkg::OP_TICK));
    send_request(mk_req(apoit_pkg::OP_LP_END));
    send_request(mk_req(apoit_pkg::OP_LP_END));
  endtask

  // Random requests under a sequence of register settings.
  task automatic test_random_phases();
    logic [15:0] vals [4];
    apoit_pkg::cfg_idx_e order [4];
    apoit_pkg::cfg_idx_e tmp;
    int unsigned j;
    sender_idles = 1'b1;
    receiver_idles <= 1'b1;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        // Largest seconds readout: huge timeout inside a huge override lead.
        0: vals = '{16'd65535, 16'd0, 16'd1, 16'd65535};
        1: vals = '{16'd65535, 16'd65535, 16'd0, 16'd0};
        2: vals = '{16'd1801, 16'd1, 16'd0, 16'd0};
        default: begin
          case ($urandom_range(9))
            0: vals[apoit_pkg::CFG_TIMEOUT] = 16'd0;
            1: vals[apoit_pkg::CFG_TIMEOUT] = 16'd65535;
            2: vals[apoit_pkg::CFG_TIMEOUT] =
                 ($urandom_range(1) ? apoit_pkg::TIMEOUT_SHORT_MAX : apoit_pkg::TIMEOUT_MID_MAX)
                 + 16'($urandom_range(1));
            3: vals[apoit_pkg::CFG_TIMEOUT] = 16'($urandom_range(65535));
            default: vals[apoit_pkg::CFG_TIMEOUT] = 16'($urandom_range(8, 1));
          endcase
          case ($urandom_range(7))
            0: vals[apoit_pkg::CFG_RATE] = 16'd0;
            1: vals[apoit_pkg::CFG_RATE] = 16'd65535;
            2: vals[apoit_pkg::CFG_RATE] = 16'($urandom_range(65535));
            default: vals[apoit_pkg::CFG_RATE] = 16'($urandom_range(4, 1));
          endcase
          vals[apoit_pkg::CFG_OVERRIDE] = 16'($urandom_range(1));
          case ($urandom_range(4))
            0: vals[apoit_pkg::CFG_LEAD_SECS] = 16'd0;
            1: vals[apoit_pkg::CFG_LEAD_SECS] = 16'd65535;
            2: vals[apoit_pkg::CFG_LEAD_SECS] = 16'($urandom_range(65535));
            default: vals[apoit_pkg::CFG_LEAD_SECS] = 16'($urandom_range(10, 1));
          endcase
        end
      endcase
      // Register writes in a shuffled order.
      order = '{apoit_pkg::CFG_TIMEOUT, apoit_pkg::CFG_RATE, apoit_pkg::CFG_OVERRIDE,
                apoit_pkg::CFG_LEAD_SECS};
      for (int i = 3; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < 4; i++) write_reg(order[i], vals[order[i]]);
      repeat (REQS_PER_PHASE) send_request(random_request());
    end
    wait_until_idle();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_receiver_hold();
    sender_idles = 1'b0;
    hold_toggle <= ~hold_toggle;
    repeat (24) send_request(random_request());
    wait_until_idle();
    sender_idles = 1'b1;
  endtask

  // Nested long processes with back-to-back traffic; only the last end reloads,
  // and an end at depth zero is ignored.
  task automatic test_nesting_back_to_back();
    sender_idles = 1'b0;
    receiver_idles <= 1'b0;
    write_reg(apoit_pkg::CFG_RATE, 16'd1);
    write_reg(apoit_pkg::CFG_TIMEOUT, 16'd100);
    repeat (NEST_DEPTH) send_request(mk_req(apoit_pkg::OP_LP_BEGIN));
    send_request(mk_req(apoit_pkg::OP_TICK));
    repeat (NEST_DEPTH - 1) send_request(mk_req(apoit_pkg::OP_LP_END));
    send_request(mk_req(apoit_pkg::OP_TICK));
    send_request(mk_req(apoit_pkg::OP_LP_END));
    send_request(mk_req(apoit_pkg::OP_TICK));
    send_request(mk_req(apoit_pkg::OP_LP_END));
    wait_until_idle();
  endtask

  // Long hold-off counter, started by a toggle of hold_toggle.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver stall pattern: a new stall density is picked each time stall_epoch wraps.
  always @(posedge clk) begin
    stall_epoch <= stall_epoch + 1'b1;
    if (stall_epoch == '0) begin
      case ($urandom_range(4))
        0, 1: stall_pct <= 0;
        2: stall_pct <= 25;
        3: stall_pct <= 50;
        default: stall_pct <= 85;
      endcase
    end
    if (hold_left != 0 || hold_toggle != hold_seen) out_stall <= 1'b1;
    else if (receiver_idles) out_stall <= ($urandom_range(99) < stall_pct);
    else out_stall <= 1'b0;
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    timer_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, timer state", 32'(timer_state),
                        32'(timer_state));
      end else begin
        exp_res = expected_results.pop_front();
        if (message !== exp_res.msg)
          report_mismatch("message", 32'(message), 32'(exp_res.msg));
        if (power_off !== exp_res.power)
          report_mismatch("power_off_command", 32'(power_off), 32'(exp_res.power));
        if (secs_valid !== exp_res.secs_valid)
          report_mismatch("seconds_valid", 32'(secs_valid), 32'(exp_res.secs_valid));
        if (secs_remaining !== exp_res.secs)
          report_mismatch("seconds_remaining", 32'(secs_remaining), 32'(exp_res.secs));
        if (timer_state !== exp_res.state)
          report_mismatch("timer_state", 32'(timer_state), 32'(exp_res.state));
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    init_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled_state();
    test_countdown_expiry();
    test_reload_causes();
    test_random_phases();
    test_receiver_hold();
    test_nesting_back_to_back();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/apoit_pkg.sv
hdl/apoit_div.sv
hdl/apoit_dp.sv
hdl/apoit_ctrl.sv
hdl/auto_power_off_inactivity_timer_top.sv
sim/tb_auto_power_off_inactivity_timer_top.sv
